// ----- src/far_pkg.sv -----
// Shared types and command codes for the fraction arithmetic reducer.
package far_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned OPW   = 32;
  localparam int unsigned RESW  = 64;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INC = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEC = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [RESW-1:0] res_num;
    logic signed [RESW-1:0] res_den;
    logic                   zero_gcd_error;
  } out_item_t;

  // Unreduced job handed from front to back.
  typedef struct packed {
    logic [RESW-1:0] num;
    logic [RESW-1:0] den;
    logic            reduce;
  } job_t;

endpackage

// ----- src/fraction_arithmetic_reducer_core.sv -----
// Fraction arithmetic reducer: valid/ready input and output channels.
//
// Each input transfer carries a command and two fractions; exactly one
// result transfer follows. Add, sub, mul and div form 64-bit cross
// products in the front end (MUL and SUM states), then the back end reduces
// both parts by their GCD. Increment, decrement and unused commands skip
// reduction; the back end passes them straight to its output register.
// Reduced commands run the binary-GCD loop and the shift back of
// common twos (one step per cycle), then two bit-serial exact divisions,
// numerator first, then denominator. The back end's iterative GCD and
// divider set the throughput; the front end and a two-entry queue let the
// next items be prepared while the back end works.
// Reset (rst, synchronous) empties the queue and idles both ends.
// A stalled receiver holds the result in the output register and,
// once the queue fills, drops ready on the input side.
module fraction_arithmetic_reducer_core import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  far_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_item(in_data), .in_valid, .in_ready,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  far_queue u_queue (
    .clk, .rst, .wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  far_back u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .out_item(out_data), .out_valid, .out_ready
  );

endmodule

// ----- src/far_front.sv -----
// Front end: sign-extend operands, form cross products (MUL state), then sums (SUM state).
module far_front import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output job_t     job,
  output logic     job_valid,
  input  logic     job_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SUM  = 4'b0100,
    S_OUT  = 4'b1000
  } fstate_t;

  fstate_t state;
  logic [CMD_W-1:0] cmd;
  logic signed [OPW-1:0] an, ad, bn, bd;
  logic signed [RESW-1:0] p0, p1, p2;
  job_t jreg;

  function automatic logic signed [OPW-1:0] sext(input logic [OPW-1:0] v);
    logic signed [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return OPW'(t);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign job_valid = (state == S_OUT);
  assign job       = jreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_OUT;
        S_OUT:  if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Signed 32 x 32 products into 64 bits; sums wrap modulo 2^64.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd <= in_item.cmd;
      an  <= sext(in_item.a_num);
      ad  <= sext(in_item.a_den);
      bn  <= sext(in_item.b_num);
      bd  <= sext(in_item.b_den);
    end
    if (state == S_MUL) begin
      p0 <= (cmd == CMD_MUL) ? an * bn : an * bd;
      p1 <= bn * ad;
      p2 <= (cmd == CMD_DIV) ? bn * ad : ad * bd;
    end
    if (state == S_SUM) begin
      case (cmd)
        CMD_ADD: jreg <= '{num: p0 + p1, den: p2, reduce: 1'b1};
        CMD_SUB: jreg <= '{num: p0 - p1, den: p2, reduce: 1'b1};
        CMD_MUL, CMD_DIV: jreg <= '{num: p0, den: p2, reduce: 1'b1};
        CMD_INC: jreg <= '{num: RESW'(an) + RESW'(ad), den: RESW'(ad), reduce: 1'b0};
        CMD_DEC: jreg <= '{num: RESW'(an) - RESW'(ad), den: RESW'(ad), reduce: 1'b0};
        default: jreg <= '{num: RESW'(an), den: RESW'(ad), reduce: 1'b0};
      endcase
    end
  end

endmodule

// ----- src/far_queue.sv -----
// Two-entry queue between front and back ends.
module far_queue import far_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t wr_data,
  input  logic wr_valid,
  output logic wr_ready,
  output job_t rd_data,
  output logic rd_valid,
  input  logic rd_ready
);

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

endmodule

// ----- src/far_back.sv -----
// Back end: binary GCD of the magnitudes, then two bit-serial exact divisions.
module far_back import far_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_valid,
  output logic      job_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_GCD   = 6'b000010,
    B_SHIFT = 6'b000100,
    B_DIVN  = 6'b001000,
    B_DIVD  = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  bstate_t state;
  logic [RESW-1:0] num, den, x, y, g, rem, quo, dividend;
  logic [6:0] k;
  logic [5:0] bit_i;
  logic sn, sd;
  out_item_t oreg;
  logic [RESW:0] trial;
  logic [RESW-1:0] rem_sh;

  assign job_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign out_item  = oreg;

  assign rem_sh = {rem[RESW-2:0], dividend[bit_i]};
  assign trial  = {rem[RESW-1], rem_sh} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            num <= job.num;
            den <= job.den;
            sn  <= job.num[RESW-1];
            sd  <= job.den[RESW-1];
            x   <= job.num[RESW-1] ? -job.num : job.num;
            y   <= job.den[RESW-1] ? -job.den : job.den;
            k   <= '0;
            if (!job.reduce) begin
              oreg  <= '{res_num: job.num, res_den: job.den, zero_gcd_error: 1'b0};
              state <= B_OUT;
            end else begin
              state <= B_GCD;
            end
          end
        end
        // Binary GCD: strip common twos, then subtract odd values.
        B_GCD: begin
          if (x == '0 || y == '0) begin
            g <= x | y;
            state <= B_SHIFT;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1; y <= y >> 1; k <= k + 7'd1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        B_SHIFT: begin
          if (g == '0) begin
            oreg  <= '{res_num: '0, res_den: '0, zero_gcd_error: 1'b1};
            state <= B_OUT;
          end else if (k != '0) begin
            g <= g << 1; k <= k - 7'd1;
          end else begin
            dividend <= sn ? -num : num;
            rem <= '0; quo <= '0; bit_i <= 6'(RESW-1);
            state <= B_DIVN;
          end
        end
        B_DIVN, B_DIVD: begin
          if (bit_i == '0) begin
            rem <= '0;
            bit_i <= 6'(RESW-1);
            if (state == B_DIVN) begin
              oreg.res_num <= sn ? -{quo[RESW-2:0], ~trial[RESW]}
                                 :  {quo[RESW-2:0], ~trial[RESW]};
              dividend <= sd ? -den : den;
              quo <= '0;
              state <= B_DIVD;
            end else begin
              oreg.res_den <= sd ? -{quo[RESW-2:0], ~trial[RESW]}
                                 :  {quo[RESW-2:0], ~trial[RESW]};
              oreg.zero_gcd_error <= 1'b0;
              state <= B_OUT;
            end
          end else begin
            if (!trial[RESW]) begin
              rem <= trial[RESW-1:0];
            end else begin
              rem <= rem_sh;
            end
            quo <= {quo[RESW-2:0], ~trial[RESW]};
            bit_i <= bit_i - 6'd1;
          end
        end
        B_OUT: if (out_ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/far_checker.sv -----
// Port-level checker for the fraction arithmetic reducer, bound to the top.
module far_port_checker import far_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_gcd_error |->
      out_data.res_num == '0 && out_data.res_den == '0)
    else $error("error flag without 0/0");

  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(in_ready) && !$isunknown(out_valid))
    else $error("handshake output unknown");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind fraction_arithmetic_reducer_core far_port_checker u_far_checker (
  .clk, .rst, .in_valid, .in_ready, .out_data, .out_valid, .out_ready
);
